// ===== design/tun_pkg.sv =====
`timescale 1ns / 1ps
package tun_pkg;

  localparam int TARGET_BITS = 30;
  localparam int OUT_W       = 16;

  typedef struct packed {
    logic                             degen;
    logic [2:0]                       neg;
    logic [2:0][TARGET_BITS-1:0]      mm;
  } side_t;

endpackage

// ===== design/triangle_unit_normal.sv =====
`timescale 1ns / 1ps
// Channel   Ports                                  Handshake
// request   in_ax .. in_cz                         start & !busy
// result    out_nx, out_ny, out_nz, out_degenerate out_valid, one cycle
//
// One request per cycle; busy is always low.
// The pipeline holds a bit-per-stage square root (31 stages) and divider (15 stages).
// Synchronous active-low reset clears the valid bits only.
// No stalls: the pipeline advances every cycle.
module triangle_unit_normal #(
  parameter int COORD_WIDTH      = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [COORD_WIDTH-1:0]      in_ax,
  input  logic signed [COORD_WIDTH-1:0]      in_ay,
  input  logic signed [COORD_WIDTH-1:0]      in_az,
  input  logic signed [COORD_WIDTH-1:0]      in_bx,
  input  logic signed [COORD_WIDTH-1:0]      in_by_coord,
  input  logic signed [COORD_WIDTH-1:0]      in_bz,
  input  logic signed [COORD_WIDTH-1:0]      in_cx,
  input  logic signed [COORD_WIDTH-1:0]      in_cy,
  input  logic signed [COORD_WIDTH-1:0]      in_cz,
  output logic                               out_valid,
  output logic signed [tun_pkg::OUT_W-1:0]   out_nx,
  output logic signed [tun_pkg::OUT_W-1:0]   out_ny,
  output logic signed [tun_pkg::OUT_W-1:0]   out_nz,
  output logic                               out_degenerate
);
  import tun_pkg::*;

  localparam int EW  = COORD_WIDTH + 1;
  localparam int PRW = 2 * EW;
  localparam int CRW = PRW + 1;
  localparam int LZW = $clog2(CRW + 1);
  localparam int PW  = CRW + TARGET_BITS;
  localparam int SQW = 2 * TARGET_BITS + 4;
  localparam int NSQ = TARGET_BITS + 1;
  localparam int LW  = TARGET_BITS + 1;
  localparam int QW  = NORMAL_FRAC_BITS + 1;
  localparam int NW  = TARGET_BITS + QW;
  localparam int RW  = LW + 1;
  localparam int XW  = (QW > OUT_W) ? QW : OUT_W;
  localparam int LAT = 10 + NSQ + QW;

  assign busy = 1'b0;

  // edges
  logic signed [EW-1:0] e1_nxt [3];
  logic signed [EW-1:0] e2_nxt [3];
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  logic                 v1_r;

  assign e1_nxt[0] = EW'(in_bx) - EW'(in_ax);
  assign e1_nxt[1] = EW'(in_by_coord) - EW'(in_ay);
  assign e1_nxt[2] = EW'(in_bz) - EW'(in_az);
  assign e2_nxt[0] = EW'(in_cx) - EW'(in_ax);
  assign e2_nxt[1] = EW'(in_cy) - EW'(in_ay);
  assign e2_nxt[2] = EW'(in_cz) - EW'(in_az);

  always_ff @(posedge clk) begin
    e1_r <= e1_nxt;
    e2_r <= e2_nxt;
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start & ~busy;
    end
  end

  // partial products
  logic signed [PRW-1:0] p_r [6];
  logic                  v2_r;

  always_ff @(posedge clk) begin
    p_r[0] <= PRW'(e1_r[1]) * PRW'(e2_r[2]);
    p_r[1] <= PRW'(e1_r[2]) * PRW'(e2_r[1]);
    p_r[2] <= PRW'(e1_r[2]) * PRW'(e2_r[0]);
    p_r[3] <= PRW'(e1_r[0]) * PRW'(e2_r[2]);
    p_r[4] <= PRW'(e1_r[0]) * PRW'(e2_r[1]);
    p_r[5] <= PRW'(e1_r[1]) * PRW'(e2_r[0]);
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  // cross product
  logic signed [CRW-1:0] c_r [3];
  logic                  v3_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      c_r[i] <= CRW'(p_r[2*i]) - CRW'(p_r[2*i+1]);
    end
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  // sign and magnitude
  logic [CRW-1:0] mag_r [3];
  logic [2:0]     neg_r;
  logic           v4_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      neg_r[i] <= c_r[i][CRW-1];
      mag_r[i] <= c_r[i][CRW-1] ? (~c_r[i] + CRW'(1)) : c_r[i];
    end
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  // leading zero count of the largest magnitude
  logic [CRW-1:0] mor;
  logic [LZW-1:0] lz_nxt;
  logic [LZW-1:0] lz_r;
  logic [CRW-1:0] mag5_r [3];
  logic [2:0]     neg5_r;
  logic           zero5_r;
  logic           v5_r;

  assign mor = mag_r[0] | mag_r[1] | mag_r[2];

  always_comb begin
    lz_nxt = LZW'(CRW);
    for (int j = 0; j < CRW; j++) begin
      if (mor[j]) lz_nxt = LZW'(CRW - 1 - j);
    end
  end

  always_ff @(posedge clk) begin
    lz_r    <= lz_nxt;
    mag5_r  <= mag_r;
    neg5_r  <= neg_r;
    zero5_r <= (mor == '0);
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  // block normalization to TARGET_BITS
  side_t          s6_nxt;
  side_t          s6_r;
  logic           v6_r;
  logic [PW-1:0]  sh [3];

  always_comb begin
    s6_nxt.degen = zero5_r;
    s6_nxt.neg   = neg5_r;
    for (int i = 0; i < 3; i++) begin
      sh[i]        = {mag5_r[i], TARGET_BITS'(0)} << lz_r;
      s6_nxt.mm[i] = sh[i][PW-1 -: TARGET_BITS];
    end
  end

  always_ff @(posedge clk) begin
    s6_r <= s6_nxt;
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
  end

  // squares
  logic [2*TARGET_BITS-1:0] sq_r [3];
  side_t                    s7_r;
  logic                     v7_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= (2*TARGET_BITS)'(s6_r.mm[i]) * (2*TARGET_BITS)'(s6_r.mm[i]);
    end
    s7_r <= s6_r;
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
  end

  // square root, one result bit per stage; index 0 holds the sum
  logic [SQW-1:0] sx_r [NSQ+1];
  logic [SQW-1:0] sr_r [NSQ+1];
  side_t          ss_r [NSQ+1];
  logic           sv_r [NSQ+1];

  always_ff @(posedge clk) begin
    sx_r[0] <= SQW'(sq_r[0]) + SQW'(sq_r[1]) + SQW'(sq_r[2]);
    sr_r[0] <= '0;
    ss_r[0] <= s7_r;
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else begin
      sv_r[0] <= v7_r;
    end
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (TARGET_BITS - k));
    logic [SQW-1:0] trial;
    logic [SQW-1:0] x_nxt;
    logic [SQW-1:0] r_nxt;

    always_comb begin
      trial = sr_r[k] + BIT;
      if (sx_r[k] >= trial) begin
        x_nxt = sx_r[k] - trial;
        r_nxt = (sr_r[k] >> 1) + BIT;
      end else begin
        x_nxt = sx_r[k];
        r_nxt = sr_r[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      sx_r[k+1] <= x_nxt;
      sr_r[k+1] <= r_nxt;
      ss_r[k+1] <= ss_r[k];
      if (!rst_n) begin
        sv_r[k+1] <= 1'b0;
      end else begin
        sv_r[k+1] <= sv_r[k];
      end
    end
  end

  // division, one quotient bit per stage, three lanes; index 0 holds the numerator
  logic [LW-1:0]  len;
  logic [RW-1:0]  drem_r [QW+1][3];
  logic [QW-1:0]  dlow_r [QW+1][3];
  logic [QW-1:0]  dq_r   [QW+1][3];
  logic [LW-1:0]  dl_r   [QW+1];
  side_t          ds_r   [QW+1];
  logic           dv_r   [QW+1];
  logic [NW-1:0]  num    [3];

  assign len = sr_r[NSQ][LW-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = NW'({ss_r[NSQ].mm[i], NORMAL_FRAC_BITS'(0)}) + NW'(len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      drem_r[0][i] <= RW'(num[i][NW-1:QW]);
      dlow_r[0][i] <= num[i][QW-1:0];
      dq_r[0][i]   <= '0;
    end
    dl_r[0] <= len;
    ds_r[0] <= ss_r[NSQ];
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else begin
      dv_r[0] <= sv_r[NSQ];
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [RW-1:0] t     [3];
    logic          ge    [3];
    logic [RW-1:0] r_nxt [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]     = {drem_r[j][i][LW-1:0], dlow_r[j][i][QW-1]};
        ge[i]    = (t[i] >= RW'(dl_r[j]));
        r_nxt[i] = ge[i] ? (t[i] - RW'(dl_r[j])) : t[i];
      end
    end

    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        drem_r[j+1][i] <= r_nxt[i];
        dlow_r[j+1][i] <= dlow_r[j][i] << 1;
        dq_r[j+1][i]   <= {dq_r[j][i][QW-2:0], ge[i]};
      end
      dl_r[j+1] <= dl_r[j];
      ds_r[j+1] <= ds_r[j];
      if (!rst_n) begin
        dv_r[j+1] <= 1'b0;
      end else begin
        dv_r[j+1] <= dv_r[j];
      end
    end
  end

  // sign, mask and output register
  logic [XW-1:0]    qe    [3];
  logic [OUT_W-1:0] n_nxt [3];
  logic [OUT_W-1:0] n_r   [3];
  logic             deg_r;
  logic             ov_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qe[i] = XW'(dq_r[QW][i]);
      if (ds_r[QW].neg[i]) qe[i] = ~qe[i] + XW'(1);
      n_nxt[i] = ds_r[QW].degen ? '0 : qe[i][OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    deg_r <= ds_r[QW].degen;
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= dv_r[QW];
    end
  end

  assign out_valid      = ov_r;
  assign out_nx         = n_r[0];
  assign out_ny         = n_r[1];
  assign out_nz         = n_r[2];
  assign out_degenerate = deg_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("request did not produce a result at the expected latency");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ##0 $past(v1_r, LAT - 1))
    else $error("result without a matching request");

  a_degen_zero: assert property (@(posedge clk)
    (out_valid && out_degenerate) |-> (out_nx == '0 && out_ny == '0 && out_nz == '0))
    else $error("degenerate result with nonzero normal");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

endmodule
